@@ rtl/core/ccc_pkg.sv @@
// shared types, codes and month length table for the calendar clock counter
package ccc_pkg;

    // function codes of an input word
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_INC  = 2'd1;
    localparam logic [1:0] FUNC_DEC  = 2'd2;

    // field select codes
    localparam logic [2:0] FIELD_SEC   = 3'd0;
    localparam logic [2:0] FIELD_MIN   = 3'd1;
    localparam logic [2:0] FIELD_HOUR  = 3'd2;
    localparam logic [2:0] FIELD_DAY   = 3'd3;
    localparam logic [2:0] FIELD_MONTH = 3'd4;
    localparam logic [2:0] FIELD_YEAR  = 3'd5;

    // field limits
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    // reset values
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [3:0] MONTH_FIRST = 4'd1;

    // port widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // full clock and calendar state
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_ccc_time;

    // leap when the year offset is a multiple of four
    function automatic logic is_leap(input logic [6:0] year);
        is_leap = (year[1:0] == 2'd0);
    endfunction

    // days in a month, february depending on the leap flag
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        unique case (month)
            4'd2:                       month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
            default:                    month_len = 5'd31;
        endcase
    endfunction

endpackage

@@ rtl/core/ccc_step.sv @@
// next-state logic: applies one tick or adjust word to the time and date
module ccc_step
    import ccc_pkg::*;
(
    input  logic [1:0] i_func,
    input  logic [2:0] i_field_select,
    input  t_ccc_time  i_cur,
    output t_ccc_time  o_nxt
);

    logic       inc, dec;
    logic       c_sec, c_min, c_hour, c_day, c_mon, c_year;
    logic       b_sec, b_min, b_hour, b_day, b_mon, b_year;
    logic       clamp;
    logic [4:0] cur_len, new_len;
    t_ccc_time  nxt;

    // decode the word
    assign inc = (i_func == FUNC_INC);
    assign dec = (i_func == FUNC_DEC);

    assign cur_len = month_len(i_cur.month, is_leap(i_cur.year));

    // carry chain upward
    assign c_sec  = (i_func == FUNC_TICK) || (inc && i_field_select == FIELD_SEC);
    assign c_min  = (inc && i_field_select == FIELD_MIN)  || (c_sec && i_cur.sec == SEC_MAX);
    assign c_hour = (inc && i_field_select == FIELD_HOUR) || (c_min && i_cur.min == MIN_MAX);
    assign c_day  = (inc && i_field_select == FIELD_DAY)  || (c_hour && i_cur.hour == HOUR_MAX);
    assign c_mon  = (inc && i_field_select == FIELD_MONTH) || (c_day && i_cur.day == cur_len);
    assign c_year = (inc && i_field_select == FIELD_YEAR)
                 || (c_mon && i_cur.month == MONTH_MAX);

    // borrow chain upward
    assign b_sec  = dec && i_field_select == FIELD_SEC;
    assign b_min  = (dec && i_field_select == FIELD_MIN)  || (b_sec && i_cur.sec == '0);
    assign b_hour = (dec && i_field_select == FIELD_HOUR) || (b_min && i_cur.min == '0);
    assign b_day  = (dec && i_field_select == FIELD_DAY)  || (b_hour && i_cur.hour == '0);
    assign b_mon  = (dec && i_field_select == FIELD_MONTH) || (b_day && i_cur.day == DAY_FIRST);
    assign b_year = (dec && i_field_select == FIELD_YEAR)
                 || (b_mon && i_cur.month == MONTH_FIRST);

    // explicit month or year step clamps the day
    assign clamp = (inc || dec)
                && (i_field_select == FIELD_MONTH || i_field_select == FIELD_YEAR);

    // time fields and year, month
    always_comb begin
        nxt = i_cur;
        if (c_sec) begin
            nxt.sec = (i_cur.sec == SEC_MAX) ? '0 : i_cur.sec + 6'd1;
        end else if (b_sec) begin
            nxt.sec = (i_cur.sec == '0) ? SEC_MAX : i_cur.sec - 6'd1;
        end
        if (c_min) begin
            nxt.min = (i_cur.min == MIN_MAX) ? '0 : i_cur.min + 6'd1;
        end else if (b_min) begin
            nxt.min = (i_cur.min == '0) ? MIN_MAX : i_cur.min - 6'd1;
        end
        if (c_hour) begin
            nxt.hour = (i_cur.hour == HOUR_MAX) ? '0 : i_cur.hour + 5'd1;
        end else if (b_hour) begin
            nxt.hour = (i_cur.hour == '0) ? HOUR_MAX : i_cur.hour - 5'd1;
        end
        if (c_mon) begin
            nxt.month = (i_cur.month == MONTH_MAX) ? MONTH_FIRST : i_cur.month + 4'd1;
        end else if (b_mon) begin
            nxt.month = (i_cur.month == MONTH_FIRST) ? MONTH_MAX : i_cur.month - 4'd1;
        end
        if (c_year) begin
            nxt.year = (i_cur.year == YEAR_MAX) ? '0 : i_cur.year + 7'd1;
        end else if (b_year) begin
            nxt.year = (i_cur.year == '0) ? YEAR_MAX : i_cur.year - 7'd1;
        end
    end

    assign new_len = month_len(nxt.month, is_leap(nxt.year));

    // day of month, after month and year are known
    always_comb begin
        o_nxt = nxt;
        if (c_day) begin
            o_nxt.day = (i_cur.day == cur_len) ? DAY_FIRST : i_cur.day + 5'd1;
        end else if (b_day) begin
            o_nxt.day = (i_cur.day == DAY_FIRST) ? new_len : i_cur.day - 5'd1;
        end else if (clamp && i_cur.day > new_len) begin
            o_nxt.day = new_len;
        end
    end

endmodule

@@ rtl/core/calendar_clock_counter_top.sv @@
// top level of the calendar clock counter with stream ports
//
// Keeps seconds, minutes, hours, day, month and year offset from 2000
// (leap every fourth year). Each input word is either a one-second tick or
// an adjust step of one selected field up or down; each word yields one
// output word with the full time and date after that word.
// Input channel: i_s_tdata carries the function code, i_s_tuser the field
// select. Output channel: o_m_tdata carries all fields and the leap flag.
// Path: an accepted word lands in the input register, and once the output
// slot is free or being drained its result is written into the state
// register that drives the output.
// Throughput: one word per cycle while the receiver does not stall; the
// whole carry and borrow chain through the date is one combinational pass
// between the input register and the state register.
// Reset: time 00:00:00, date day 1, month 1, year 0; both stages empty.
// When the receiver stalls, the output word holds, the input register
// keeps one more word and the input side then stalls as well.
module calendar_clock_counter_top
    import ccc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [1:0] func, rest zero
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // [2:0] field_select
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // second_out, minute_out, hour_out, day_out,
                                             // month_out, year_out, leap_flag, zero fill
);

    logic       r_in_valid;
    logic [1:0] r_func;
    logic [2:0] r_sel;
    logic       r_out_valid;
    t_ccc_time  r_time;
    t_ccc_time  n_time;
    logic       move;

    // input word advances when the output slot is free or being drained
    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_func <= i_s_tdata[1:0];
            r_sel  <= i_s_tuser;
        end
    end

    // next state for the held word
    ccc_step u_step (
        .i_func         (r_func),
        .i_field_select (r_sel),
        .i_cur          (r_time),
        .o_nxt          (n_time)
    );

    // state register doubles as the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.sec   <= '0;
            r_time.min   <= '0;
            r_time.hour  <= '0;
            r_time.day   <= DAY_FIRST;
            r_time.month <= MONTH_FIRST;
            r_time.year  <= '0;
        end else if (move) begin
            r_time <= n_time;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // pack the output word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, is_leap(r_time.year), r_time.year, r_time.month,
                         r_time.day, r_time.hour, r_time.min, r_time.sec};

endmodule
